// ===== src/bmns_pkg.sv =====
package bmns_pkg;

  localparam int U_BITS = 16;
  localparam int F_BITS = 16;
  localparam int Z_BITS = 5 + F_BITS;
  localparam int LOG_BITS = 28;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS = 31;
  localparam int P_W = $clog2(U_BITS);
  localparam int CNT_W = 5;
  localparam int QDEPTH = 2;

  localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] QUARTER_PI_Q30 = 32'd843314857;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // One queued item: generate a pair, or replay the kept sine value.
  typedef struct packed {
    logic              gen;
    logic [U_BITS-1:0] ua;
    logic [U_BITS-1:0] ub;
  } item_t;

  typedef logic [31:0] atan_tab_t [CORDIC_STEPS];

  // Restoring division, used only while building constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] rem;
    q = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Arctangent of 2^-i in Q.30 from its power series.
  function automatic logic [31:0] atan_q30(input int i);
    logic signed [63:0] acc;
    logic [63:0] term;
    int e;
    acc = '0;
    if (i == 0) return QUARTER_PI_Q30;
    for (int k = 0; k < 31; k++) begin
      e = 60 - i * (2 * k + 1);
      if (e >= 0) begin
        term = udiv64(64'd1 << e, 64'(2 * k + 1));
        if (k % 2 == 1) acc = acc - $signed(term);
        else acc = acc + $signed(term);
      end
    end
    return 32'((acc + 64'sd536870912) >>> 30);
  endfunction

  function automatic atan_tab_t atan_table();
    atan_tab_t t;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      t[i] = atan_q30(i);
    end
    return t;
  endfunction

endpackage

// ===== src/bmns_ifs.sv =====
interface bmns_in_if;
  logic                        valid;
  logic                        ready;
  logic [bmns_pkg::U_BITS-1:0] uniform_a;
  logic [bmns_pkg::U_BITS-1:0] uniform_b;
  modport source (output valid, uniform_a, uniform_b, input ready);
  modport sink (input valid, uniform_a, uniform_b, output ready);
endinterface

interface bmns_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic        from_cache;
  logic        saturated;
  modport source (output valid, sample, from_cache, saturated, input ready);
  modport sink (input valid, sample, from_cache, saturated, output ready);
endinterface

// ===== src/box_muller_normal_sampler.sv =====
// Channel  | Dir | Payload                             | Handshake
// in_s     | in  | uniform_a, uniform_b                | valid/ready
// out_s    | out | sample, from_cache, saturated       | valid/ready
// cfg_*    | in  | mean_offset @0x0, std_scale @0x4    | APB, pready high
//
// A pair request runs in the back end through 28 log2 squaring steps, 31
// square root steps and 30 rotation steps, plus multiply and output steps.
// A replay request goes straight to the multiply and output steps.
// Reset is synchronous, active low; it clears the phase, queue and sequencer.
// The two-entry queue keeps accepting items, until it is full, while the
// back end works or the output register waits to be taken.
module box_muller_normal_sampler (
  input  logic        clk,
  input  logic        rst_n,
  bmns_in_if.sink     in_s,
  bmns_out_if.source  out_s,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_MEAN = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  logic signed [31:0] mean_r;
  logic [31:0] scale_r;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_nempty;
  logic [1:0] q_count;
  bmns_pkg::item_t q_in;
  bmns_pkg::item_t q_head;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SCALE) ? scale_r : mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r <= '0;
      scale_r <= 32'd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_MEAN) mean_r <= cfg_pwdata;
      else scale_r <= cfg_pwdata;
    end
  end

  bmns_front u_front (
    .clk(clk), .rst_n(rst_n), .in_s(in_s),
    .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  bmns_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in), .pop(q_pop),
    .head(q_head), .not_empty(q_nempty), .full(q_full), .count(q_count)
  );

  bmns_back u_back (
    .clk(clk), .rst_n(rst_n), .q_head(q_head), .q_valid(q_nempty), .q_pop(q_pop),
    .mean(mean_r), .scale(scale_r), .out_s(out_s)
  );

  // The queue never overfills and never pops while empty.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 2'(bmns_pkg::QDEPTH)) else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nempty) else $error("pop from empty queue");

endmodule

// ===== src/bmns_front.sv =====
module bmns_front (
  input  logic                clk,
  input  logic                rst_n,
  bmns_in_if.sink             in_s,
  input  logic                q_full,
  output logic                q_push,
  output bmns_pkg::item_t     q_item
);

  logic cache_full_r;
  logic accept;
  logic nonzero;

  // Items are taken whenever the queue has room.
  assign in_s.ready = !q_full;
  assign accept = in_s.valid && in_s.ready;
  assign nonzero = (in_s.uniform_a != '0);

  // A generating item with a zero first uniform is dropped here.
  assign q_push = accept && (cache_full_r || nonzero);
  assign q_item.gen = !cache_full_r;
  assign q_item.ua = in_s.uniform_a;
  assign q_item.ub = in_s.uniform_b;

  // Phase flag: set by an accepted pair request with a nonzero first uniform, cleared by the replay.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_full_r <= 1'b0;
    end else if (accept) begin
      if (cache_full_r) begin
        cache_full_r <= 1'b0;
      end else if (nonzero) begin
        cache_full_r <= 1'b1;
      end
    end
  end

endmodule

// ===== src/bmns_queue.sv =====
module bmns_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bmns_pkg::item_t     push_item,
  input  logic                pop,
  output bmns_pkg::item_t     head,
  output logic                not_empty,
  output logic                full,
  output logic [1:0]          count
);

  bmns_pkg::item_t mem_r [bmns_pkg::QDEPTH];
  logic wp_r;
  logic rp_r;
  logic [1:0] cnt_r;

  assign head = mem_r[rp_r];
  assign not_empty = (cnt_r != 2'd0);
  assign full = (cnt_r == 2'(bmns_pkg::QDEPTH));
  assign count = cnt_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (push && !pop) cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

// ===== src/bmns_back.sv =====
module bmns_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bmns_pkg::item_t     q_head,
  input  logic                q_valid,
  output logic                q_pop,
  input  logic signed [31:0]  mean,
  input  logic [31:0]         scale,
  bmns_out_if.source          out_s
);

  localparam int Z_W = bmns_pkg::Z_BITS;
  localparam int F_W = bmns_pkg::F_BITS;
  localparam bmns_pkg::atan_tab_t ATAN = bmns_pkg::atan_table();

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOG  = 4'd1;
  localparam logic [3:0] S_VMUL = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_ROT  = 4'd4;
  localparam logic [3:0] S_ZC   = 4'd5;
  localparam logic [3:0] S_ZS   = 4'd6;
  localparam logic [3:0] S_EMUL = 4'd7;
  localparam logic [3:0] S_EOUT = 4'd8;

  logic [3:0] st_r;
  logic [bmns_pkg::CNT_W-1:0] cnt_r;
  logic [bmns_pkg::P_W-1:0] p_r;
  logic [31:0] m_r;
  logic [bmns_pkg::LOG_BITS-1:0] f_r;
  logic [61:0] sq_n_r;
  logic [61:0] sq_res_r;
  logic [61:0] sq_bit_r;
  logic signed [32:0] zr_r;
  logic signed [33:0] x_r;
  logic signed [33:0] y_r;
  logic [1:0] quad_r;
  logic cached_r;
  logic signed [Z_W-1:0] z_r;
  logic signed [Z_W-1:0] kept_r;
  logic signed [53:0] eprod_r;
  logic ov_r;
  logic [31:0] osample_r;
  logic ocache_r;
  logic osat_r;

  logic [bmns_pkg::P_W-1:0] p_enc;
  logic [31:0] t_turn;
  logic [60:0] ang_prod;
  logic [63:0] m_sq;
  logic [31:0] m_sh;
  logic [32:0] lval;
  logic [61:0] v_prod;
  logic [61:0] sq_trial;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic signed [32:0] at;
  logic signed [33:0] cs;
  logic signed [33:0] sn;
  logic signed [31:0] rad;
  logic signed [Z_W-1:0] zc;
  logic signed [Z_W-1:0] zs;
  logic signed [55:0] ssum;
  logic [31:0] s_val;
  logic s_sat;
  logic out_free;

  // Scale a Q.58 product to Q.F_BITS with half-up rounding, clamped to Z_W bits.
  function automatic logic signed [Z_W-1:0] to_z(input logic signed [65:0] prod);
    logic signed [65:0] z;
    logic signed [65:0] hi;
    z = (prod + (66'sd1 <<< (57 - F_W))) >>> (58 - F_W);
    hi = (66'sd1 <<< (Z_W - 1)) - 66'sd1;
    if (z > hi) z = hi;
    if (z < -hi - 66'sd1) z = -hi - 66'sd1;
    return Z_W'(z);
  endfunction

  // Top set bit of the first uniform.
  always_comb begin
    p_enc = '0;
    for (int i = 0; i < bmns_pkg::U_BITS; i++) begin
      if (q_head.ua[i]) p_enc = bmns_pkg::P_W'(i);
    end
  end

  // Angle: quadrant from the top two turn bits, the rest scaled by pi/2.
  assign t_turn = 32'(q_head.ub) << (32 - bmns_pkg::U_BITS);
  assign ang_prod = 61'(t_turn[29:0]) * 61'(bmns_pkg::HALF_PI_Q30);

  // One log2 squaring step.
  assign m_sq = 64'(m_r) * 64'(m_r);
  assign m_sh = m_sq[61:30];

  // -2 ln u1 in Q.28 from -log2 u1.
  assign lval = ((33'(bmns_pkg::U_BITS) - 33'(p_r)) << bmns_pkg::LOG_BITS) - 33'(f_r);
  assign v_prod = 62'(lval) * 62'(bmns_pkg::TWO_LN2_Q28);

  // Square root trial subtraction.
  assign sq_trial = sq_res_r + sq_bit_r;

  // Rotation step.
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = $signed({1'b0, ATAN[cnt_r]});

  // Quadrant fold and radius scaling.
  always_comb begin
    case (quad_r)
      2'd0: begin cs = x_r; sn = y_r; end
      2'd1: begin cs = -y_r; sn = x_r; end
      2'd2: begin cs = -x_r; sn = -y_r; end
      default: begin cs = y_r; sn = -x_r; end
    endcase
  end
  assign rad = $signed({1'b0, sq_res_r[30:0]});
  assign zc = to_z(66'(rad) * 66'(cs));
  assign zs = to_z(66'(rad) * 66'(sn));

  // Final rounding, offset and saturation.
  always_comb begin
    ssum = ((56'(eprod_r) + (56'sd1 <<< (F_W - 1))) >>> F_W) + 56'(mean);
    s_sat = 1'b0;
    s_val = ssum[31:0];
    if (ssum > 56'sd2147483647) begin
      s_val = 32'h7FFF_FFFF;
      s_sat = 1'b1;
    end else if (ssum < -56'sd2147483648) begin
      s_val = 32'h8000_0000;
      s_sat = 1'b1;
    end
  end

  assign out_free = !ov_r || out_s.ready;
  assign q_pop = (st_r == S_IDLE) && q_valid;

  assign out_s.valid = ov_r;
  assign out_s.sample = osample_r;
  assign out_s.from_cache = ocache_r;
  assign out_s.saturated = osat_r;

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        cached_r <= !q_head.gen;
        z_r <= kept_r;
        p_r <= p_enc;
        m_r <= 32'(q_head.ua) << (30 - 32'(p_enc));
        f_r <= '0;
        quad_r <= t_turn[31:30];
        zr_r <= $signed({2'b0, ang_prod[60:30]});
      end
      S_LOG: begin
        if (m_sh[31]) begin
          m_r <= m_sh >> 1;
          f_r <= {f_r[bmns_pkg::LOG_BITS-2:0], 1'b1};
        end else begin
          m_r <= m_sh;
          f_r <= {f_r[bmns_pkg::LOG_BITS-2:0], 1'b0};
        end
      end
      S_VMUL: begin
        sq_n_r <= {v_prod[61:28], 28'b0};
        sq_res_r <= '0;
        sq_bit_r <= 62'd1 << 60;
      end
      S_SQRT: begin
        if (sq_n_r >= sq_trial) begin
          sq_n_r <= sq_n_r - sq_trial;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        x_r <= bmns_pkg::CORDIC_GAIN_Q30;
        y_r <= '0;
      end
      S_ROT: begin
        if (zr_r >= 0) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          zr_r <= zr_r - at;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          zr_r <= zr_r + at;
        end
      end
      S_ZC: z_r <= zc;
      S_ZS: kept_r <= zs;
      S_EMUL: eprod_r <= 54'(z_r) * $signed({22'b0, scale});
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (q_valid) st_r <= q_head.gen ? S_LOG : S_EMUL;
        end
        S_LOG: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == bmns_pkg::CNT_W'(bmns_pkg::LOG_BITS - 1)) st_r <= S_VMUL;
        end
        S_VMUL: begin
          cnt_r <= '0;
          st_r <= S_SQRT;
        end
        S_SQRT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == bmns_pkg::CNT_W'(bmns_pkg::SQRT_STEPS - 1)) begin
            cnt_r <= '0;
            st_r <= S_ROT;
          end
        end
        S_ROT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == bmns_pkg::CNT_W'(bmns_pkg::CORDIC_STEPS - 1)) st_r <= S_ZC;
        end
        S_ZC: st_r <= S_ZS;
        S_ZS: st_r <= S_EMUL;
        S_EMUL: st_r <= S_EOUT;
        S_EOUT: begin
          if (out_free) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Output register: loaded on the final step, cleared when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (st_r == S_EOUT && out_free) begin
      ov_r <= 1'b1;
    end else if (out_s.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_EOUT && out_free) begin
      osample_r <= s_val;
      ocache_r <= cached_r;
      osat_r <= s_sat;
    end
  end

endmodule
